[design/stq_pkg.sv]
// Shared types, sizes and codes for the sorted timer queue.
`default_nettype none
package stq_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int TIME_BITS  = 32;
  localparam int ID_W       = 4;
  localparam int ID_COUNT   = 1 << ID_W;
  localparam int FIELD_W    = 32;
  localparam int IVL_W      = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ARM  = 1'b1;

  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_EXPIRED  = 2'd1;
  localparam logic [1:0] ST_ARMED    = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    timer_id;
    logic [FIELD_W-1:0] first_delay;
    logic [FIELD_W-1:0] period;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    timer_id_res;
    logic [FIELD_W-1:0] fire_time;
  } rsp_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [ID_W-1:0]      id;
  } entry_t;

  typedef struct packed {
    logic                 pop;
    logic                 ins;
    logic [TIME_BITS-1:0] now_time;
    logic [IVL_W-1:0]     interval;
    entry_t               new_entry;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[design/stq_cell.sv]
// One list slot: holds an entry, shifts toward the head on pop, opens a gap on insert.
`default_nettype none
module stq_cell (
  input  wire logic                clk,
  input  wire stq_pkg::cell_ctrl_t ctrl,
  input  wire logic                occ,
  input  wire logic                found_in,
  output logic                     found_out,
  input  wire stq_pkg::entry_t     prev,
  input  wire stq_pkg::entry_t     next,
  output stq_pkg::entry_t          q
);

  logic [stq_pkg::TIME_BITS-1:0] remain;
  logic                          gt;
  logic                          here;

  always_comb begin
    remain    = q.deadline - ctrl.now_time;
    gt        = stq_pkg::IVL_W'(remain) > ctrl.interval;
    here      = !found_in && (!occ || gt);
    found_out = found_in || !occ || gt;
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      q <= next;
    end else if (ctrl.ins) begin
      if (found_in) begin
        q <= prev;
      end else if (here) begin
        q <= ctrl.new_entry;
      end
    end
  end

endmodule
`default_nettype wire

[design/sorted_timer_queue_unit.sv]
// Top level: sequencer, timer table and the chain of list cells.
//
//   channel  payload  direction  handshake
//   req      req_t    in         req_valid / req_stall
//   rsp      rsp_t    out        rsp_valid / rsp_stall
//
// An arm beat steps from accept through check, insert and result; a rejected arm
// goes from check to result, a tick without expiry from tick to result, and an
// expiring tick through pop, reinsert and result. Insert compares all cells
// against the new interval at once; the cell chain shifts one slot per pop or insert.
// rst clears time, count, active flags and handshake state; list cells are not reset.
// A held result does not block the next request beat.
`default_nettype none
module sorted_timer_queue_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire stq_pkg::req_t   req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output stq_pkg::rsp_t        rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TICK = 3'd1;
  localparam logic [2:0] S_ARM  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                       state;
  stq_pkg::req_t                    cur;
  logic [stq_pkg::TIME_BITS-1:0]    now_time;
  logic [stq_pkg::TIME_BITS-1:0]    now_next;
  logic [stq_pkg::CNT_W-1:0]        entry_count;
  logic [stq_pkg::ID_COUNT-1:0]     timer_active;
  logic [stq_pkg::FIELD_W-1:0]      timer_period [stq_pkg::ID_COUNT];
  logic [stq_pkg::IVL_W-1:0]        interval;
  logic [stq_pkg::ID_W-1:0]         ins_id;
  stq_pkg::rsp_t                    pend;

  stq_pkg::cell_ctrl_t              ctrl;
  stq_pkg::entry_t                  cell_q [stq_pkg::MAX_TIMERS];
  logic [stq_pkg::MAX_TIMERS:0]     found;
  logic [stq_pkg::MAX_TIMERS-1:0]   occ;

  logic [stq_pkg::TIME_BITS-1:0]    diff;
  logic                             expired;
  logic [63:0]                      now_wide;
  logic [stq_pkg::FIELD_W-1:0]      arm_ivl;
  logic                             arm_ok;

  always_comb begin
    now_next = now_time + stq_pkg::TIME_BITS'(1);
    diff     = now_next - cell_q[0].deadline;
    expired  = (entry_count != '0) && !diff[stq_pkg::TIME_BITS-1];
    now_wide = 64'(now_next);
    arm_ivl  = (cur.first_delay != '0) ? cur.first_delay : cur.period;
    arm_ok   = !timer_active[cur.timer_id] &&
               (entry_count != stq_pkg::CNT_W'(stq_pkg::MAX_TIMERS));
  end

  always_comb begin
    ctrl                    = '0;
    ctrl.pop                = (state == S_TICK) && expired;
    ctrl.ins                = (state == S_INS);
    ctrl.now_time           = now_time;
    ctrl.interval           = interval;
    ctrl.new_entry.deadline = now_time + stq_pkg::TIME_BITS'(interval);
    ctrl.new_entry.id       = ins_id;
  end

  assign found[0]  = 1'b0;
  assign req_stall = (state != S_IDLE);

  for (genvar i = 0; i < stq_pkg::MAX_TIMERS; i++) begin : g_cell
    stq_pkg::entry_t prev_e;
    stq_pkg::entry_t next_e;

    assign occ[i] = entry_count > stq_pkg::CNT_W'(i);

    if (i == 0) begin : g_first
      assign prev_e = ctrl.new_entry;
    end else begin : g_mid
      assign prev_e = cell_q[i-1];
    end

    if (i == stq_pkg::MAX_TIMERS - 1) begin : g_last
      assign next_e = cell_q[i];
    end else begin : g_body
      assign next_e = cell_q[i+1];
    end

    stq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ[i]),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .prev      (prev_e),
      .next      (next_e),
      .q         (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      now_time     <= '0;
      entry_count  <= '0;
      timer_active <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= (req.kind == stq_pkg::KIND_ARM) ? S_ARM : S_TICK;
          end
        end
        S_TICK: begin
          now_time <= now_next;
          if (expired) begin
            entry_count       <= entry_count - stq_pkg::CNT_W'(1);
            ins_id            <= cell_q[0].id;
            interval          <= stq_pkg::IVL_W'(timer_period[cell_q[0].id]);
            pend.status       <= stq_pkg::ST_EXPIRED;
            pend.timer_id_res <= cell_q[0].id;
            pend.fire_time    <= now_wide[stq_pkg::FIELD_W-1:0];
            state             <= S_INS;
          end else begin
            pend  <= '0;
            state <= S_DONE;
          end
        end
        S_ARM: begin
          pend.timer_id_res <= cur.timer_id;
          pend.fire_time    <= '0;
          if (arm_ok) begin
            timer_active[cur.timer_id] <= 1'b1;
            timer_period[cur.timer_id] <= cur.period;
            ins_id                     <= cur.timer_id;
            interval                   <= stq_pkg::IVL_W'(arm_ivl);
            pend.status                <= stq_pkg::ST_ARMED;
            state                      <= S_INS;
          end else begin
            pend.status <= stq_pkg::ST_REJECTED;
            state       <= S_DONE;
          end
        end
        S_INS: begin
          entry_count <= entry_count + stq_pkg::CNT_W'(1);
          state       <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= pend;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
